### design/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
`default_nettype none
package upd_pkg;

   // Character codes used by the decoder.
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;
   localparam logic [7:0] CharUpperA  = 8'h41;
   localparam logic [7:0] CharUpperF  = 8'h46;
   localparam logic [7:0] CharLowerA  = 8'h61;
   localparam logic [7:0] CharLowerF  = 8'h66;
   localparam logic [7:0] HexAlphaBase = 8'd10;

   // Lookahead hold codes.
   localparam logic [1:0] HeldNone    = 2'd0;
   localparam logic [1:0] HeldPercent = 2'd1;
   localparam logic [1:0] HeldDigit   = 2'd2;

   // Most decoded bytes that one input word can cause.
   localparam int RunBytes = 3;
   localparam int RunIdxWidth = $clog2(RunBytes);

   // Input word.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_end;
   } req_word_type;

   // Output word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_string_end;
      logic       out_run_last;
   } rsp_word_type;

   // The decoded bytes caused by one input word, in emission order.
   typedef struct packed {
      logic [RunBytes-1:0][7:0] run_bytes;
      logic [1:0]               count;
      logic                     string_end;
   } run_type;

   // True for 0-9, A-F and a-f.
   function automatic logic is_hex_digit(input logic [7:0] b);
      return ((b >= CharZero) && (b <= CharNine)) ||
             ((b >= CharUpperA) && (b <= CharUpperF)) ||
             ((b >= CharLowerA) && (b <= CharLowerF));
   endfunction

   // Nibble value of a hex digit; zero for anything else.
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      v = 8'd0;
      if ((b >= CharZero) && (b <= CharNine)) begin
         v = b - CharZero;
      end else if ((b >= CharUpperA) && (b <= CharUpperF)) begin
         v = b - CharUpperA + HexAlphaBase;
      end else if ((b >= CharLowerA) && (b <= CharLowerF)) begin
         v = b - CharLowerA + HexAlphaBase;
      end
      return v[3:0];
   endfunction

endpackage
`default_nettype wire

### design/upd_front.sv
// Front end: accepts raw words, tracks the lookahead hold and builds one run per word.
`default_nettype none
module upd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire upd_pkg::req_word_type req_word,
   input  wire logic                  queue_full,
   output logic                       req_stall,
   output logic                       push_valid,
   output upd_pkg::run_type           push_run
);

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_digit_ff, held_digit_in;
   logic       accept;
   logic       byte_hex;
   logic       take_hold;
   logic       decode;
   logic [1:0] pre_n;
   logic       plain_out;
   logic [7:0] plain_byte;
   logic [1:0] plain_count;
   logic [7:0] b;

   assign b         = req_word.in_byte;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign byte_hex  = upd_pkg::is_hex_digit(b);

   // Classify the word against what is currently held.
   always_comb begin
      take_hold = 1'b0;
      decode    = 1'b0;
      pre_n     = 2'd0;
      unique case (held_count_ff)
         upd_pkg::HeldPercent: begin
            if (byte_hex && !req_word.in_end) begin
               take_hold = 1'b1;
            end else begin
               pre_n = 2'd1;
            end
         end
         upd_pkg::HeldDigit: begin
            if (byte_hex) begin
               decode = 1'b1;
            end else begin
               pre_n = 2'd2;
            end
         end
         default: pre_n = 2'd0;
      endcase
   end

   // Ordinary handling of the new byte once any held bytes are flushed.
   always_comb begin
      plain_out  = !((b == upd_pkg::CharPercent) && !req_word.in_end);
      plain_byte = (b == upd_pkg::CharPlus) ? upd_pkg::CharSpace : b;
      plain_count = pre_n + {1'b0, plain_out};
   end

   // Assemble the run and the next hold state.
   always_comb begin
      held_count_in = held_count_ff;
      held_digit_in = held_digit_ff;
      push_run      = '0;
      push_run.string_end = req_word.in_end;
      if (take_hold) begin
         push_run.count = 2'd0;
      end else if (decode) begin
         push_run.count = 2'd1;
         push_run.run_bytes[0] = {upd_pkg::hex_value(held_digit_ff), upd_pkg::hex_value(b)};
      end else begin
         push_run.count = plain_count;
         push_run.run_bytes[0] = (pre_n != 2'd0) ? upd_pkg::CharPercent : plain_byte;
         push_run.run_bytes[1] = (pre_n == 2'd2) ? held_digit_ff : plain_byte;
         push_run.run_bytes[2] = plain_byte;
      end
      push_valid = accept && (push_run.count != 2'd0);
      if (accept) begin
         if (take_hold) begin
            held_count_in = upd_pkg::HeldDigit;
            held_digit_in = b;
         end else if (!decode && !plain_out) begin
            held_count_in = upd_pkg::HeldPercent;
         end else begin
            held_count_in = upd_pkg::HeldNone;
         end
      end
   end

   // Hold state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= upd_pkg::HeldNone;
         held_digit_ff <= 8'd0;
      end else begin
         held_count_ff <= held_count_in;
         held_digit_ff <= held_digit_in;
      end
   end

endmodule
`default_nettype wire

### design/upd_queue.sv
// Short run queue between the front end and the back end.
`default_nettype none
module upd_queue #(
   parameter int Depth = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire upd_pkg::run_type push_run,
   input  wire logic             pop,
   output logic                  full,
   output logic                  nonempty,
   output upd_pkg::run_type      head_run
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   upd_pkg::run_type    entries_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign nonempty = (count_ff != '0);
   assign head_run = entries_ff[rd_ptr_ff];
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && nonempty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule
`default_nettype wire

### design/upd_back.sv
// Back end: takes runs from the queue and sends their bytes one word per cycle while not stalled.
`default_nettype none
module upd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             queue_nonempty,
   input  wire upd_pkg::run_type head_run,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output upd_pkg::rsp_word_type rsp_word
);

   upd_pkg::run_type               cur_ff, cur_in;
   logic                           cur_valid_ff, cur_valid_in;
   logic [upd_pkg::RunIdxWidth-1:0] idx_ff, idx_in;
   logic                           last;
   logic                           sent;
   logic                           load;

   assign rsp_valid = cur_valid_ff;
   assign last      = (idx_ff == upd_pkg::RunIdxWidth'(cur_ff.count - 2'd1));
   assign sent      = cur_valid_ff && !rsp_stall;
   assign load      = !cur_valid_ff || (sent && last);
   assign pop       = load && queue_nonempty;

   // Output word from the current run.
   always_comb begin
      rsp_word.out_byte       = cur_ff.run_bytes[idx_ff];
      rsp_word.out_string_end = last && cur_ff.string_end;
      rsp_word.out_run_last   = last;
   end

   // Step through the run, fetching the next one as the last byte leaves.
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = head_run;
         cur_valid_in = queue_nonempty;
         idx_in       = '0;
      end else if (sent) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

### design/url_percent_decoder_core.sv
// URL percent decoder (form-urlencoded): top level joining front end, run queue and back end.
// A decoded word passes the run queue and then the back end's run register before it is offered.
// Throughput: one input word per cycle while the run queue has room, and one output word
// per cycle while the output is not stalled; the run queue absorbs runs of three words.
// The input stalls only while the run queue (QueueDepth entries) is full.
// Reset is synchronous and active high: it clears the lookahead hold, queue and output.
`default_nettype none
module url_percent_decoder_core #(
   parameter int QueueDepth = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire upd_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output upd_pkg::rsp_word_type      rsp_word
);

   logic             queue_full;
   logic             queue_nonempty;
   logic             push_valid;
   logic             pop;
   upd_pkg::run_type push_run;
   upd_pkg::run_type head_run;

   // Classification of incoming words.
   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push_valid (push_valid),
      .push_run   (push_run)
   );

   // Decoupling queue of runs.
   upd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_run   (push_run),
      .pop        (pop),
      .full       (queue_full),
      .nonempty   (queue_nonempty),
      .head_run   (head_run)
   );

   // Serialisation of runs onto the output.
   upd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_nonempty (queue_nonempty),
      .head_run       (head_run),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word)
   );

endmodule
`default_nettype wire
